[design/bpa_pkg.sv]
package bpa_pkg;

    // Field widths of the request and result transactions
    localparam int ORDER_W  = 4;
    localparam int COUNT_W  = 11;
    localparam int OFFSET_W = 10;
    localparam int STATUS_W = 2;
    localparam int PAGES_W  = 11;
    localparam int ROUND_W  = COUNT_W + 1;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_TREE_ORDER = 1'b0;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic                req_type;
        logic [COUNT_W-1:0]  page_count;
        logic [OFFSET_W-1:0] page_offset;
    } bpa_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] block_offset;
        logic [PAGES_W-1:0]  block_pages;
        logic [PAGES_W-1:0]  largest_free;
    } bpa_result_t;

    // Round a nonzero page count up to the next power of two
    function automatic logic [ROUND_W-1:0] round_pow2(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] x;
        begin
            x = count - COUNT_W'(1);
            x = x | (x >> 1);
            x = x | (x >> 2);
            x = x | (x >> 4);
            x = x | (x >> 8);
            round_pow2 = {1'b0, x} + ROUND_W'(1);
        end
    endfunction

endpackage

[design/bpa_engine.sv]
module bpa_engine #(
    parameter int LOG2_MAX_PAGES = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rebuild,
    input  logic [bpa_pkg::ORDER_W-1:0]   order,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bpa_pkg::bpa_req_t             req,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bpa_pkg::bpa_result_t          result
);
    import bpa_pkg::*;

    localparam int SW    = LOG2_MAX_PAGES + 1;
    localparam int IW    = LOG2_MAX_PAGES + 1;
    localparam int OW    = LOG2_MAX_PAGES;
    localparam int XW    = (SW + 1 > 12) ? SW + 1 : 12;
    localparam int NODES = (2 ** IW) - 1;

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_IDLE, S_A_RD, S_A_CMP, S_A_MARK,
        S_F_RD, S_F_CHK, S_U_RD, S_U_WR, S_DONE
    } state_t;

    state_t state_reg;

    logic [IW-1:0]       idx_reg;
    logic [SW-1:0]       size_reg;
    logic [SW-1:0]       want_reg;
    logic [SW-1:0]       cur_reg;
    logic [SW-1:0]       pages_reg;
    logic [SW-1:0]       root_reg;
    logic [OW-1:0]       off_reg;
    logic [OW-1:0]       offin_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                free_reg;
    logic                out_valid_reg;
    bpa_result_t         result_reg;

    // Tree memory: largest free block under each node
    logic [SW-1:0] tree_mem [NODES];
    logic [SW-1:0] rd_data_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] wr_data;

    logic [SW-1:0] m;
    logic [XW-1:0] m_x;
    logic [XW-1:0] want_x;
    logic [XW-1:0] offset_x;
    logic [IW-1:0] last_idx;
    logic [IW:0]   k1;
    logic [IW:0]   k2;
    logic [IW-1:0] left_idx;
    logic [IW-1:0] right_idx;
    logic [IW-1:0] sib_idx;
    logic [IW-1:0] parent_idx;
    logic [SW-1:0] psize;
    logic [SW:0]   pair_sum;
    logic [SW-1:0] pair_max;
    logic [SW-1:0] new_val;
    logic [XW-1:0] off_ext;
    logic [XW-1:0] pages_ext;
    logic [XW-1:0] root_ext;
    logic          result_load;

    // Managed pages, saturated at the largest tree
    always_comb
    begin
        if (int'(order) > LOG2_MAX_PAGES)
        begin
            m = SW'(1) << LOG2_MAX_PAGES;
        end
        else
        begin
            m = SW'(1) << order;
        end
    end

    assign m_x      = XW'(m);
    assign want_x   = XW'(round_pow2(req.page_count));
    assign offset_x = XW'(req.page_offset);
    assign last_idx = IW'((m_x << 1) - XW'(2));
    assign k1       = {1'b0, idx_reg} + (IW + 1)'(1);
    assign k2       = {1'b0, idx_reg} + (IW + 1)'(2);

    // Tree navigation
    assign left_idx   = {idx_reg[IW-2:0], 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign sib_idx    = idx_reg[0] ? (idx_reg + IW'(1)) : (idx_reg - IW'(1));
    assign parent_idx = (idx_reg - IW'(1)) >> 1;

    // Parent value from the path child and its sibling
    assign psize    = size_reg << 1;
    assign pair_sum = {1'b0, cur_reg} + {1'b0, rd_data_reg};
    assign pair_max = (cur_reg > rd_data_reg) ? cur_reg : rd_data_reg;
    assign new_val  = (free_reg && (pair_sum == {1'b0, psize})) ? psize : pair_max;

    assign off_ext   = XW'(off_reg);
    assign pages_ext = XW'(pages_reg);
    assign root_ext  = XW'(root_reg);

    // Load the output register once the previous result has left
    assign result_load = !rebuild && (state_reg == S_DONE)
                         && (!out_valid_reg || !out_stall);

    // Memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = size_reg;
        case (state_reg)
            S_INIT:
            begin
                wr_en = 1'b1;
            end
            S_A_RD:
            begin
                rd_en   = (size_reg != want_reg);
                rd_addr = left_idx;
            end
            S_A_MARK:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            S_U_RD:
            begin
                rd_en   = (idx_reg != '0);
                rd_addr = sib_idx;
            end
            S_U_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = parent_idx;
                wr_data = new_val;
            end
            S_F_RD:
            begin
                rd_en = 1'b1;
            end
            S_F_CHK:
            begin
                wr_en = (rd_data_reg == '0);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Tree storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tree_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= tree_mem[rd_addr];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            idx_reg       <= '0;
            size_reg      <= '0;
            want_reg      <= '0;
            cur_reg       <= '0;
            pages_reg     <= '0;
            root_reg      <= '0;
            off_reg       <= '0;
            offin_reg     <= '0;
            status_reg    <= ST_OK;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            // Shadow the root for checks and the result
            if (wr_en && (wr_addr == '0))
            begin
                root_reg <= wr_data;
            end

            // Raise valid on a new result, drop it once taken
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (rebuild)
            begin
                state_reg <= S_LOAD;
            end
            else
            begin
                case (state_reg)
                    S_LOAD:
                    begin
                        idx_reg   <= '0;
                        size_reg  <= m;
                        state_reg <= S_INIT;
                    end
                    S_INIT:
                    begin
                        if (idx_reg == last_idx)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IW'(1);
                            if ((k1 & k2) == '0)
                            begin
                                size_reg <= size_reg >> 1;
                            end
                        end
                    end
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            off_reg   <= '0;
                            pages_reg <= '0;
                            cur_reg   <= '0;
                            free_reg  <= (req.req_type == REQ_FREE);
                            if (req.req_type == REQ_ALLOC)
                            begin
                                if (req.page_count == '0 || want_x > m_x)
                                begin
                                    status_reg <= ST_BAD_ARG;
                                    state_reg  <= S_DONE;
                                end
                                else if (want_x > root_ext)
                                begin
                                    status_reg <= ST_NO_SPACE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    size_reg  <= m;
                                    want_reg  <= SW'(want_x);
                                    state_reg <= S_A_RD;
                                end
                            end
                            else
                            begin
                                if (offset_x >= m_x)
                                begin
                                    status_reg <= ST_BAD_ARG;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg   <= IW'(offset_x + m_x - XW'(1));
                                    size_reg  <= SW'(1);
                                    offin_reg <= OW'(offset_x);
                                    state_reg <= S_F_RD;
                                end
                            end
                        end
                    end
                    S_A_RD:
                    begin
                        if (size_reg == want_reg)
                        begin
                            state_reg <= S_A_MARK;
                        end
                        else
                        begin
                            state_reg <= S_A_CMP;
                        end
                    end
                    S_A_CMP:
                    begin
                        // Prefer the left child when it holds the request
                        size_reg <= size_reg >> 1;
                        if (rd_data_reg >= want_reg)
                        begin
                            idx_reg <= left_idx;
                        end
                        else
                        begin
                            idx_reg <= right_idx;
                            off_reg <= off_reg + OW'(size_reg >> 1);
                        end
                        state_reg <= S_A_RD;
                    end
                    S_A_MARK:
                    begin
                        cur_reg    <= '0;
                        pages_reg  <= size_reg;
                        status_reg <= ST_OK;
                        state_reg  <= S_U_RD;
                    end
                    S_F_RD:
                    begin
                        state_reg <= S_F_CHK;
                    end
                    S_F_CHK:
                    begin
                        if (rd_data_reg == '0)
                        begin
                            cur_reg    <= size_reg;
                            pages_reg  <= size_reg;
                            off_reg    <= offin_reg & ~OW'(size_reg - SW'(1));
                            status_reg <= ST_OK;
                            state_reg  <= S_U_RD;
                        end
                        else if (idx_reg == '0)
                        begin
                            status_reg <= ST_NOT_ALLOC;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= parent_idx;
                            size_reg  <= size_reg << 1;
                            state_reg <= S_F_RD;
                        end
                    end
                    S_U_RD:
                    begin
                        if (idx_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_U_WR;
                        end
                    end
                    S_U_WR:
                    begin
                        idx_reg   <= parent_idx;
                        size_reg  <= psize;
                        cur_reg   <= new_val;
                        state_reg <= S_U_RD;
                    end
                    S_DONE:
                    begin
                        // Hold until the output register is free
                        if (result_load)
                        begin
                            result_reg.status       <= status_reg;
                            result_reg.block_offset <= off_ext[OFFSET_W-1:0];
                            result_reg.block_pages  <= pages_ext[PAGES_W-1:0];
                            result_reg.largest_free <= root_ext[PAGES_W-1:0];
                            state_reg               <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_LOAD;
                    end
                endcase
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || rebuild;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

[design/buddy_page_allocator_unit.sv]
// Binary buddy page allocator over 2^tree_order pages (tree_order saturates
// at LOG2_MAX_PAGES). The free-block tree lives in one on-chip memory with a
// single registered read port, and one sequencer walks it a level at a time.
// An allocate descends from the root a level at a time (read, then compare) and
// then updates each level on the way back to the root; a free climbs from the
// leaf to the used block (read, then check) and then updates each level from
// there to the root. Rejected requests go straight to the result. After reset
// and after every write of tree_order the tree is rebuilt by a sweep over every
// node, one node per cycle, during which in_stall stays high. Results wait in
// an output register, so a new request is taken while the previous result is
// still held by out_stall.
module buddy_page_allocator_unit #(
    parameter int LOG2_MAX_PAGES = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpa_pkg::ADDR_W-1:0]     paddr,
    input  logic [bpa_pkg::DATA_W-1:0]     pwdata,
    output logic [bpa_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic [bpa_pkg::COUNT_W-1:0]    page_count,
    input  logic [bpa_pkg::OFFSET_W-1:0]   page_offset,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bpa_pkg::STATUS_W-1:0]   status,
    output logic [bpa_pkg::OFFSET_W-1:0]   block_offset,
    output logic [bpa_pkg::PAGES_W-1:0]    block_pages,
    output logic [bpa_pkg::PAGES_W-1:0]    largest_free
);
    import bpa_pkg::*;

    logic [ORDER_W-1:0]  order_reg;
    logic                rebuild_reg;
    logic [ADDR_W-3:0]   reg_index;
    logic                cfg_write;
    bpa_req_t            req;
    bpa_result_t         result;

    // Register decode
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_index == REG_TREE_ORDER);
    assign pready    = 1'b1;
    assign prdata    = (reg_index == REG_TREE_ORDER)
                       ? DATA_W'(order_reg) : '0;

    // Hold the order; start a rebuild the cycle after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg   <= ORDER_RESET;
            rebuild_reg <= 1'b0;
        end
        else
        begin
            rebuild_reg <= cfg_write;
            if (cfg_write)
            begin
                order_reg <= pwdata[ORDER_W-1:0];
            end
        end
    end

    assign req.req_type    = req_type;
    assign req.page_count  = page_count;
    assign req.page_offset = page_offset;

    bpa_engine #(
        .LOG2_MAX_PAGES (LOG2_MAX_PAGES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .rebuild   (rebuild_reg),
        .order     (order_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req       (req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign status       = result.status;
    assign block_offset = result.block_offset;
    assign block_pages  = result.block_pages;
    assign largest_free = result.largest_free;

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int MAX_ORDER     = 10;
    localparam int NODE_COUNT    = (2 << MAX_ORDER) - 1;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_LIMIT   = 50;
    localparam logic [ADDR_W-1:0] ADDR_TREE_ORDER = {REG_TREE_ORDER, 2'b00};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic                req_type;
    logic [COUNT_W-1:0]  page_count;
    logic [OFFSET_W-1:0] page_offset;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] block_offset;
    logic [PAGES_W-1:0]  block_pages;
    logic [PAGES_W-1:0]  largest_free;

    // Shadow copy of the free-block tree and the order in use
    logic [PAGES_W-1:0]  free_tree [NODE_COUNT];
    int unsigned         managed_pages;
    int unsigned         active_order;

    // Blocks the shadow tree currently holds as allocated
    int unsigned         live_base [$];
    int unsigned         live_size [$];

    bpa_result_t         expected_results [$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int                  sender_idle_pct = 0;
    int                  receiver_stall_pct = 0;
    logic                hold_off = 1'b0;

    buddy_page_allocator_unit #(
        .LOG2_MAX_PAGES(MAX_ORDER)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .page_count(page_count),
        .page_offset(page_offset),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .block_offset(block_offset),
        .block_pages(block_pages),
        .largest_free(largest_free)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mark every node of a fully free tree with its block size
    function automatic void rebuild_free_tree(input logic [ORDER_W-1:0] ord);
        int unsigned size;
        active_order  = (ord > MAX_ORDER) ? MAX_ORDER : ord;
        managed_pages = 1 << active_order;
        size = 2 * managed_pages;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            if (i < 2 * managed_pages - 1)
            begin
                if (((i + 1) & i) == 0)
                    size >>= 1;
                free_tree[i] = PAGES_W'(size);
            end
            else
            begin
                free_tree[i] = '0;
            end
        end
        live_base.delete();
        live_size.delete();
    endfunction

    // Apply one request to the shadow tree and return the outcome it must give
    function automatic bpa_result_t serve_request(input bpa_req_t req);
        bpa_result_t res;
        int unsigned want;
        int unsigned node;
        int unsigned size;
        int unsigned lsum;
        int unsigned lval;
        int unsigned rval;
        res = '0;
        res.status = ST_OK;
        if (req.req_type == REQ_ALLOC)
        begin
            want = 1;
            while (want < req.page_count)
                want <<= 1;
            if (req.page_count == 0 || want > managed_pages)
                res.status = ST_BAD_ARG;
            else if (want > free_tree[0])
                res.status = ST_NO_SPACE;
            else
            begin
                // Descend, left child first whenever it fits
                node = 0;
                for (size = managed_pages; size != want; size >>= 1)
                    node = (free_tree[2 * node + 1] >= want) ? 2 * node + 1 : 2 * node + 2;
                free_tree[node] = '0;
                res.block_offset = OFFSET_W'((node + 1) * size - managed_pages);
                res.block_pages  = PAGES_W'(size);
                while (node != 0)
                begin
                    node = (node + 1) / 2 - 1;
                    lval = free_tree[2 * node + 1];
                    rval = free_tree[2 * node + 2];
                    free_tree[node] = PAGES_W'((lval > rval) ? lval : rval);
                end
            end
        end
        else
        begin
            if (req.page_offset >= managed_pages)
                res.status = ST_BAD_ARG;
            else
            begin
                // Climb from the leaf to the first used node
                node = req.page_offset + managed_pages - 1;
                size = 1;
                while (free_tree[node] != 0 && node != 0)
                begin
                    node = (node + 1) / 2 - 1;
                    size <<= 1;
                end
                if (free_tree[node] != 0)
                    res.status = ST_NOT_ALLOC;
                else
                begin
                    res.block_offset = OFFSET_W'((node + 1) * size - managed_pages);
                    res.block_pages  = PAGES_W'(size);
                    free_tree[node]  = PAGES_W'(size);
                    // Merge upward wherever both halves are wholly free
                    while (node != 0)
                    begin
                        node = (node + 1) / 2 - 1;
                        size <<= 1;
                        lval = free_tree[2 * node + 1];
                        rval = free_tree[2 * node + 2];
                        lsum = lval + rval;
                        if (lsum == size)
                            free_tree[node] = PAGES_W'(size);
                        else
                            free_tree[node] = PAGES_W'((lval > rval) ? lval : rval);
                    end
                end
            end
        end
        res.largest_free = free_tree[0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want_val);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want_val);
        mismatch_count++;
    endtask

    // Compare one accepted result with the oldest outstanding expectation
    task automatic check_result(input bpa_result_t got);
        bpa_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing outstanding", got.status, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.block_offset !== want.block_offset)
            report_mismatch("block_offset", got.block_offset, want.block_offset);
        if (got.block_pages !== want.block_pages)
            report_mismatch("block_pages", got.block_pages, want.block_pages);
        if (got.largest_free !== want.largest_free)
            report_mismatch("largest_free", got.largest_free, want.largest_free);
    endtask

    // Take results and pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result(bpa_result_t'({status, block_offset, block_pages, largest_free}));
        out_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
    end

    // Abort a run that hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL buddy_page_allocator_unit");
        $finish;
    end

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_stall_pct <= receiver_pct;
    endtask

    // Drive one request transaction and record its outcome once accepted
    task automatic send_request(input logic kind, input logic [COUNT_W-1:0] cnt,
                                input logic [OFFSET_W-1:0] off);
        bpa_req_t    req;
        bpa_result_t res;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        page_count  <= cnt;
        page_offset <= off;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        req = bpa_req_t'({kind, cnt, off});
        res = serve_request(req);
        expected_results.push_back(res);
        // Track live blocks so later frees can target them
        if (res.status == ST_OK)
        begin
            if (kind == REQ_ALLOC)
            begin
                live_base.push_back(res.block_offset);
                live_size.push_back(res.block_pages);
            end
            else
            begin
                for (int i = 0; i < live_base.size(); i++)
                begin
                    if (live_base[i] == res.block_offset)
                    begin
                        live_base.delete(i);
                        live_size.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write tree_order over the register port; the block rebuilds its tree
    task automatic configure_order(input int unsigned ord);
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TREE_ORDER;
        pwdata  <= DATA_W'(ord);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rebuild_free_tree(ORDER_W'(ord));
    endtask

    // Mostly well-formed allocate/free traffic, some raw noise
    task automatic send_random_request();
        int unsigned        pick;
        int unsigned        lvl;
        int unsigned        idx;
        logic [COUNT_W-1:0] cnt;
        logic [OFFSET_W-1:0] off;
        pick = $urandom_range(99);
        cnt  = COUNT_W'($urandom_range(0, 2047));
        off  = OFFSET_W'($urandom_range(0, 1023));
        if (pick < 8)
        begin
            send_request(pick[0], cnt, off);
        end
        else if (pick < 55 || live_base.size() == 0)
        begin
            // Favor small blocks, reach the whole range now and then
            lvl = $urandom_range(0, $urandom_range(0, active_order));
            if (lvl == 0)
                cnt = COUNT_W'(1);
            else
                cnt = COUNT_W'($urandom_range((1 << (lvl - 1)) + 1, 1 << lvl));
            send_request(REQ_ALLOC, cnt, off);
        end
        else
        begin
            idx = $urandom_range(0, live_base.size() - 1);
            off = OFFSET_W'(live_base[idx] + $urandom_range(0, live_size[idx] - 1));
            send_request(REQ_FREE, cnt, off);
        end
    endtask

    task automatic run_random(input int n);
        repeat (n)
            send_random_request();
    endtask

    // Field extremes and every status at the reset order
    task automatic test_directed();
        set_idling(0, 0);
        send_request(REQ_ALLOC, 11'd0, 10'd0);
        send_request(REQ_ALLOC, 11'd2047, 10'd0);
        send_request(REQ_ALLOC, 11'd1025, 10'd0);
        send_request(REQ_ALLOC, 11'd1024, 10'd0);
        send_request(REQ_ALLOC, 11'd1, 10'd0);
        send_request(REQ_FREE, 11'd0, 10'd1023);
        send_request(REQ_FREE, 11'd0, 10'd0);
        send_request(REQ_ALLOC, 11'd3, 10'd0);
        send_request(REQ_ALLOC, 11'd1, 10'd0);
        send_request(REQ_ALLOC, 11'd5, 10'd0);
        send_request(REQ_FREE, 11'd0, 10'd2);
        send_request(REQ_FREE, 11'd0, 10'd5);
        send_request(REQ_FREE, 11'd0, 10'd4);
        send_request(REQ_FREE, 11'd0, 10'd8);
        send_request(REQ_ALLOC, 11'd512, 10'd0);
        send_request(REQ_ALLOC, 11'd512, 10'd0);
        send_request(REQ_ALLOC, 11'd2, 10'd0);
        send_request(REQ_FREE, 11'd0, 10'd700);
        send_request(REQ_FREE, 11'd0, 10'd0);
        send_request(REQ_ALLOC, 11'd1, 10'd1023);
        send_request(REQ_FREE, 11'd2047, 10'd0);
    endtask

    // Walk tree_order through its extremes, saturation included
    task automatic test_order_settings();
        int unsigned order_list [7] = '{0, 1, 4, 15, 11, 7, 10};
        set_idling(13, 13);
        foreach (order_list[i])
        begin
            configure_order(order_list[i]);
            send_request(REQ_ALLOC, COUNT_W'(managed_pages), 10'd0);
            send_request(REQ_FREE, 11'd0, 10'd1023);
            send_request(REQ_ALLOC, COUNT_W'(managed_pages + 1), 10'd0);
            run_random(36);
        end
    endtask

    // Long random traffic under each idling mix
    task automatic test_random_phases();
        set_idling(0, 0);
        run_random(320);
        set_idling(84, 0);
        run_random(320);
        configure_order(6);
        set_idling(0, 84);
        run_random(320);
        configure_order(10);
        set_idling(13, 13);
        run_random(320);
    endtask

    // Hold the output off long enough that the block stalls its input
    task automatic test_backpressure();
        wait_results_drained();
        set_idling(0, 0);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        run_random(20);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        req_type    = REQ_ALLOC;
        page_count  = '0;
        page_offset = '0;
        rebuild_free_tree(ORDER_RESET);
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_order_settings();
        test_random_phases();
        test_backpressure();

        // Drain, then give the block time to show any stray result
        wait_results_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS buddy_page_allocator_unit");
        else
            $display("FAIL buddy_page_allocator_unit");
        $finish;
    end

endmodule
